>>> rtl/core/sdtw_pkg.sv
package sdtw_pkg;

	localparam int ACC_W   = 48;
	localparam int COST_W  = 32;
	localparam int WGT_W   = 17;
	localparam int CNT_W   = 17;
	localparam int PADDR_W = 4;
	localparam int MUL_A_W = 40;
	localparam int MUL_B_W = 17;
	localparam int MUL_W   = MUL_A_W + MUL_B_W;
	localparam int ZSUM_W  = 18;
	localparam int DIVD_W  = 33;
	localparam int DIV_STEPS = 4;
	localparam int DIV_CYCLES = 9;
	localparam int DIV_PAD_W = DIV_STEPS * DIV_CYCLES;

	localparam logic signed [ACC_W-1:0] ACC_INF = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [MUL_B_W-1:0] LOG2E_Q16 = 17'd94548;
	localparam logic [MUL_B_W-1:0] LN2_Q16   = 17'd45426;
	localparam logic [ZSUM_W-1:0]  ONE_Q16   = 18'd65536;

	localparam logic [1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [1:0] REG_COL_COUNT = 2'd1;
	localparam logic [1:0] REG_SHARPNESS = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MIN,
		ST_DIFF,
		ST_MUL_N,
		ST_MUL_E,
		ST_MUL_IDX,
		ST_EXP_TAB,
		ST_EXP,
		ST_LN_MUL,
		ST_LN_TAB,
		ST_LN_SCALE,
		ST_SOFT_DIV,
		ST_SOFT_WAIT,
		ST_WT_DIV,
		ST_WT_WAIT,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_DN,
		MUL_LOG2E,
		MUL_IDX,
		MUL_LNF,
		MUL_LN2
	} mul_sel_t;

	// Bitwise integer square root, used only while building the power table.
	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] bm;
		v  = v_in;
		r  = '0;
		bm = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (bm > v) begin
				bm = bm >> 2;
			end
		end
		for (int i = 0; i < 32; i++) begin
			if (bm != 64'd0) begin
				if (v >= r + bm) begin
					v = v - (r + bm);
					r = (r >> 1) + bm;
				end else begin
					r = r >> 1;
				end
				bm = bm >> 2;
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/core/sdtw_div.sv
module sdtw_div
	import sdtw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [ZSUM_W-1:0] divisor,
	output logic              busy,
	output logic              done,
	output logic [WGT_W-1:0]  quotient
);

	logic [DIV_PAD_W-1:0] quo_q;
	logic [ZSUM_W:0]      rem_q;
	logic [ZSUM_W-1:0]    den_q;
	logic [3:0]           cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_PAD_W-1:0] quo_nxt;
	logic [ZSUM_W:0]      rem_nxt;

	// Four restoring steps per cycle while busy.
	always_comb begin
		quo_nxt = quo_q;
		rem_nxt = rem_q;
		for (int s = 0; s < DIV_STEPS; s++) begin
			rem_nxt = {rem_nxt[ZSUM_W-1:0], quo_nxt[DIV_PAD_W-1]};
			quo_nxt = {quo_nxt[DIV_PAD_W-2:0], 1'b0};
			if (rem_nxt >= {1'b0, den_q}) begin
				rem_nxt    = rem_nxt - {1'b0, den_q};
				quo_nxt[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(DIV_CYCLES);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= DIV_PAD_W'(dividend);
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q[WGT_W-1:0];

endmodule

>>> rtl/core/sdtw_rom.sv
module sdtw_rom #(
	parameter int EXP_TABLE_DEPTH = 1024
) (
	input  logic                               clk,
	input  logic [$clog2(EXP_TABLE_DEPTH)-1:0] addr,
	output logic [32:0]                        pow_q,
	output logic [31:0]                        lg_q
);

	typedef logic [32:0] pow_tab_t [EXP_TABLE_DEPTH];
	typedef logic [31:0] lg_tab_t [EXP_TABLE_DEPTH];

	// 2^(-k/D) in Q1.32 from a product of repeated square roots of one half.
	function automatic pow_tab_t build_pow();
		pow_tab_t     tab;
		logic [63:0]  roots [33];
		logic [63:0]  x;
		logic [127:0] acc;
		roots[0] = 64'h8000_0000;
		for (int b = 1; b <= 32; b++) begin
			roots[b] = sdtw_pkg::isqrt64(roots[b-1] << 32);
		end
		for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
			x   = (64'(k) << 32) / EXP_TABLE_DEPTH;
			acc = 128'(1) << 32;
			for (int p = 31; p >= 0; p--) begin
				if (x[p]) begin
					acc = (acc * 128'(roots[32-p])) >> 32;
				end
			end
			tab[k] = acc[32:0];
		end
		return tab;
	endfunction

	// log2(1 + k/D) in Q0.32, one bit per squaring.
	function automatic lg_tab_t build_lg();
		lg_tab_t     tab;
		logic [63:0] y;
		logic [31:0] lg;
		for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
			y  = (64'(1) << 30) + ((64'(k) << 30) / EXP_TABLE_DEPTH);
			lg = '0;
			for (int p = 31; p >= 0; p--) begin
				y = (y * y) >> 30;
				if (y >= (64'(2) << 30)) begin
					y     = y >> 1;
					lg[p] = 1'b1;
				end
			end
			tab[k] = lg;
		end
		return tab;
	endfunction

	localparam pow_tab_t POW_TAB = build_pow();
	localparam lg_tab_t  LG_TAB  = build_lg();

	always_ff @(posedge clk) begin
		pow_q <= POW_TAB[addr];
		lg_q  <= LG_TAB[addr];
	end

endmodule

>>> rtl/core/soft_dtw_forward_cell_core.sv
// Soft-DTW forward cell. Costs (signed Q16.16) enter one word per cell in
// row-major order; each word yields the saturated Q32.16 accumulated value,
// the three soft-argmin weights in Q1.16 and a flag on the final cell. The
// matrix position is tracked inside, so set row_count, col_count and
// sharpness over APB (0x0, 0x4, 0x8) before streaming a matrix. Each cell
// is worked in steps: a single shared 40x17 multiplier walks the exp and
// log table lookups for the three neighbours, and one radix-16 divider
// performs the division by sharpness and the three weight normalizations
// in turn. A new cell is taken as soon as the previous one is written to
// the output register, even while that result is still waiting to be
// taken.
module soft_dtw_forward_cell_core
	import sdtw_pkg::*;
#(
	parameter int MAX_COLS        = 1024,
	parameter int MAX_ROWS        = 1024,
	parameter int EXP_TABLE_DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  logic                     cell_valid,
	output logic                     cell_ready,
	input  logic signed [COST_W-1:0] cost,
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic signed [ACC_W-1:0]  accumulated,
	output logic [WGT_W-1:0]         weight_left,
	output logic [WGT_W-1:0]         weight_up,
	output logic [WGT_W-1:0]         weight_diag,
	output logic                     last_cell
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int IW = $clog2(EXP_TABLE_DEPTH);

	// Configuration registers.
	logic [10:0] row_count_q;
	logic [10:0] col_count_q;
	logic [7:0]  sharp_q;
	logic        cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= 11'd1;
			col_count_q <= 11'd1;
			sharp_q     <= 8'd1;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_ROW_COUNT: row_count_q <= pwdata[10:0];
				REG_COL_COUNT: col_count_q <= pwdata[10:0];
				REG_SHARPNESS: sharp_q     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ROW_COUNT: prdata = 32'(row_count_q);
			REG_COL_COUNT: prdata = 32'(col_count_q);
			REG_SHARPNESS: prdata = 32'(sharp_q);
			default:       prdata = '0;
		endcase
	end

	logic [7:0]       n_eff;
	logic [CNT_W-1:0] eff_rows;
	logic [CNT_W-1:0] eff_cols;

	assign n_eff = (sharp_q == 8'd0) ? 8'd1 : sharp_q;

	always_comb begin
		if (row_count_q == 11'd0)
			eff_rows = CNT_W'(1);
		else if (CNT_W'(row_count_q) > CNT_W'(MAX_ROWS))
			eff_rows = CNT_W'(MAX_ROWS);
		else
			eff_rows = CNT_W'(row_count_q);
		if (col_count_q == 11'd0)
			eff_cols = CNT_W'(1);
		else if (CNT_W'(col_count_q) > CNT_W'(MAX_COLS))
			eff_cols = CNT_W'(MAX_COLS);
		else
			eff_cols = CNT_W'(col_count_q);
	end

	// Sequencer and datapath state.
	state_t state_q, state_nxt;
	mul_sel_t mul_sel;
	logic     div_start;
	logic     div_busy;
	logic     div_done;
	logic [WGT_W-1:0] div_quo;
	logic [DIVD_W-1:0] div_dividend;
	logic [ZSUM_W-1:0] div_divisor;

	logic [RW-1:0] row_index_q;
	logic [CW-1:0] col_index_q;
	logic signed [ACC_W-1:0] left_q;
	logic signed [ACC_W-1:0] diag_q;
	logic signed [ACC_W-1:0] prev_rd_q;
	logic signed [ACC_W-1:0] prev_row_mem [MAX_COLS];

	logic signed [COST_W-1:0] cost_q;
	logic signed [ACC_W-1:0]  x_q [3];
	logic signed [ACC_W-1:0]  up_q;
	logic signed [ACC_W-1:0]  xmin_q;
	logic [ACC_W:0]           d_q;
	logic [1:0]               i_q;
	logic [4:0]               p_q;
	logic [WGT_W-1:0]         e_q [3];
	logic [ZSUM_W-1:0]        z_q;
	logic signed [ACC_W:0]    soft_q;
	logic [WGT_W-1:0]         w_q [3];
	logic [MUL_W-1:0]         mul_q;
	logic [32:0]              pow_q;
	logic [31:0]              lg_q;

	logic signed [ACC_W-1:0] out_acc_q;
	logic [WGT_W-1:0]        out_wl_q, out_wu_q, out_wd_q;
	logic                    out_last_q;
	logic                    out_valid_q;

	logic       d_big;
	logic       p_big;
	logic       ln_g;
	logic [15:0] ln_f;
	logic [WGT_W-1:0] e_new;
	logic       row_end;
	logic       mat_end;
	logic       finish;
	logic signed [ACC_W+1:0] acc_sum;
	logic signed [ACC_W-1:0] acc_sat;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;

	assign d_big = |d_q[ACC_W:32];
	assign p_big = mul_q[MUL_W-1:32] >= 25'd17;
	assign ln_g  = z_q[ZSUM_W-1];
	// With Z in [1.0, 4.0), the mantissa fraction is a plain bit slice.
	assign ln_f  = ln_g ? z_q[16:1] : z_q[15:0];
	assign e_new = WGT_W'(pow_q[32:16] >> p_q);

	assign row_end = (CNT_W'(col_index_q) + CNT_W'(1)) >= eff_cols;
	assign mat_end = row_end && ((CNT_W'(row_index_q) + CNT_W'(1)) >= eff_rows);

	assign acc_sum = (ACC_W+2)'(cost_q) + (ACC_W+2)'(soft_q);
	always_comb begin
		if (acc_sum > (ACC_W+2)'(ACC_INF))
			acc_sat = ACC_INF;
		else if (acc_sum < -(ACC_W+2)'(ACC_INF) - (ACC_W+2)'(1))
			acc_sat = ~ACC_INF;
		else
			acc_sat = acc_sum[ACC_W-1:0];
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:      if (cell_valid) state_nxt = ST_FETCH;
			ST_FETCH:     state_nxt = ST_MIN;
			ST_MIN:       state_nxt = ST_DIFF;
			ST_DIFF:      state_nxt = ST_MUL_N;
			ST_MUL_N: begin
				if (!d_big)
					state_nxt = ST_MUL_E;
				else if (i_q == 2'd2)
					state_nxt = ST_LN_MUL;
				else
					state_nxt = ST_DIFF;
			end
			ST_MUL_E:     state_nxt = ST_MUL_IDX;
			ST_MUL_IDX: begin
				if (!p_big)
					state_nxt = ST_EXP_TAB;
				else if (i_q == 2'd2)
					state_nxt = ST_LN_MUL;
				else
					state_nxt = ST_DIFF;
			end
			ST_EXP_TAB:   state_nxt = ST_EXP;
			ST_EXP:       state_nxt = (i_q == 2'd2) ? ST_LN_MUL : ST_DIFF;
			ST_LN_MUL:    state_nxt = ST_LN_TAB;
			ST_LN_TAB:    state_nxt = ST_LN_SCALE;
			ST_LN_SCALE:  state_nxt = ST_SOFT_DIV;
			ST_SOFT_DIV:  state_nxt = ST_SOFT_WAIT;
			ST_SOFT_WAIT: if (div_done) state_nxt = ST_WT_DIV;
			ST_WT_DIV:    state_nxt = ST_WT_WAIT;
			ST_WT_WAIT: begin
				if (div_done)
					state_nxt = (i_q == 2'd2) ? ST_DONE : ST_WT_DIV;
			end
			ST_DONE:      if (finish) state_nxt = ST_IDLE;
			default:      state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		cell_ready = 1'b0;
		mul_sel    = MUL_NONE;
		div_start  = 1'b0;
		finish     = 1'b0;
		unique case (state_q)
			ST_IDLE:     cell_ready = 1'b1;
			ST_MUL_N:    if (!d_big) mul_sel = MUL_DN;
			ST_MUL_E:    mul_sel = MUL_LOG2E;
			ST_MUL_IDX:  if (!p_big) mul_sel = MUL_IDX;
			ST_LN_MUL:   mul_sel = MUL_LNF;
			ST_LN_SCALE: mul_sel = MUL_LN2;
			ST_SOFT_DIV: div_start = 1'b1;
			ST_WT_DIV:   div_start = 1'b1;
			ST_DONE:     finish = !out_valid_q || result_ready;
			default: ;
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_SOFT_DIV: begin
				div_dividend = DIVD_W'(mul_q[48:32]);
				div_divisor  = ZSUM_W'(n_eff);
			end
			default: begin
				div_dividend = {e_q[i_q], 16'd0};
				div_divisor  = z_q;
			end
		endcase
	end

	// The shared multiplier.
	always_comb begin
		unique case (mul_sel)
			MUL_DN:    begin mul_a = MUL_A_W'(d_q[31:0]);     mul_b = MUL_B_W'(n_eff); end
			MUL_LOG2E: begin mul_a = mul_q[MUL_A_W-1:0];      mul_b = LOG2E_Q16; end
			MUL_IDX:   begin mul_a = MUL_A_W'(mul_q[31:16]);  mul_b = MUL_B_W'(EXP_TABLE_DEPTH); end
			MUL_LNF:   begin mul_a = MUL_A_W'(ln_f);          mul_b = MUL_B_W'(EXP_TABLE_DEPTH); end
			MUL_LN2:   begin mul_a = MUL_A_W'({ln_g, lg_q});  mul_b = LN2_Q16; end
			default:   begin mul_a = '0;                      mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_sel != MUL_NONE)
			mul_q <= MUL_W'(mul_a) * MUL_W'(mul_b);
	end

	sdtw_rom #(
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_rom (
		.clk   (clk),
		.addr  (mul_q[16 +: IW]),
		.pow_q (pow_q),
		.lg_q  (lg_q)
	);

	sdtw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Row buffer holding the accumulated values of the row above.
	always_ff @(posedge clk) begin
		if (finish)
			prev_row_mem[col_index_q] <= acc_sat;
		prev_rd_q <= prev_row_mem[col_index_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_index_q <= '0;
			col_index_q <= '0;
			left_q      <= ACC_INF;
			diag_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (finish) begin
				out_valid_q <= 1'b1;
				if (mat_end) begin
					row_index_q <= '0;
					col_index_q <= '0;
					left_q      <= ACC_INF;
					diag_q      <= '0;
				end else if (row_end) begin
					row_index_q <= row_index_q + RW'(1);
					col_index_q <= '0;
					left_q      <= ACC_INF;
					diag_q      <= ACC_INF;
				end else begin
					col_index_q <= col_index_q + CW'(1);
					left_q      <= acc_sat;
					diag_q      <= up_q;
				end
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cell_valid)
					cost_q <= cost;
			end
			ST_FETCH: begin
				x_q[0] <= (col_index_q == '0) ? ACC_INF : left_q;
				x_q[1] <= (row_index_q == '0) ? ACC_INF : prev_rd_q;
				up_q   <= (row_index_q == '0) ? ACC_INF : prev_rd_q;
				x_q[2] <= (col_index_q == '0 && row_index_q != '0) ? ACC_INF : diag_q;
			end
			ST_MIN: begin
				if (x_q[1] < x_q[0] && x_q[1] <= x_q[2])
					xmin_q <= x_q[1];
				else if (x_q[2] < x_q[0] && x_q[2] < x_q[1])
					xmin_q <= x_q[2];
				else
					xmin_q <= x_q[0];
				i_q <= 2'd0;
				z_q <= '0;
			end
			ST_DIFF: begin
				d_q <= (ACC_W+1)'(x_q[i_q]) - (ACC_W+1)'(xmin_q);
			end
			ST_MUL_N: begin
				if (d_big) begin
					e_q[i_q] <= '0;
					i_q      <= i_q + 2'd1;
				end
			end
			ST_MUL_IDX: begin
				p_q <= mul_q[36:32];
				if (p_big) begin
					e_q[i_q] <= '0;
					i_q      <= i_q + 2'd1;
				end
			end
			ST_EXP: begin
				e_q[i_q] <= e_new;
				z_q      <= z_q + ZSUM_W'(e_new);
				i_q      <= i_q + 2'd1;
			end
			ST_SOFT_WAIT: begin
				if (div_done) begin
					soft_q <= (ACC_W+1)'(xmin_q) - (ACC_W+1)'(div_quo);
					i_q    <= 2'd0;
				end
			end
			ST_WT_WAIT: begin
				if (div_done) begin
					w_q[i_q] <= div_quo;
					i_q      <= i_q + 2'd1;
				end
			end
			ST_DONE: begin
				if (finish) begin
					out_acc_q  <= acc_sat;
					out_wl_q   <= w_q[0];
					out_wu_q   <= w_q[1];
					out_wd_q   <= w_q[2];
					out_last_q <= mat_end;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = out_valid_q;
	assign accumulated  = out_acc_q;
	assign weight_left  = out_wl_q;
	assign weight_up    = out_wu_q;
	assign weight_diag  = out_wd_q;
	assign last_cell    = out_last_q;

	logic [WGT_W+1:0] wsum;
	assign wsum = (WGT_W+2)'(out_wl_q) + (WGT_W+2)'(out_wu_q) + (WGT_W+2)'(out_wd_q);

	// Truncated weights lose less than one LSB each.
	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (wsum >= 19'd65534 && wsum <= 19'd65536))
		else $error("soft-argmin weights do not sum to one");

	// The minimum neighbour always contributes exactly one to the sum.
	a_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LN_MUL |-> (z_q >= ONE_Q16 && z_q <= 18'd196608))
		else $error("exponent sum out of range");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

endmodule

>>> sim/soft_dtw_cell_checker.sv
`timescale 1ns / 100ps

module soft_dtw_cell_checker
	import sdtw_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [31:0]              pwdata,
	input  logic                     pready,
	input  logic                     cell_valid,
	input  logic                     cell_ready,
	input  logic signed [COST_W-1:0] cost,
	input  logic                     result_valid,
	input  logic                     result_ready,
	input  logic signed [ACC_W-1:0]  accumulated,
	input  logic [WGT_W-1:0]         weight_left,
	input  logic [WGT_W-1:0]         weight_up,
	input  logic [WGT_W-1:0]         weight_diag,
	input  logic                     last_cell,
	output int                       pending,
	output int                       errors
);

	localparam int DEPTH = 1024;
	localparam int LIM   = 1024;
	localparam int MAX_ROWS_T = 1024;
	localparam logic signed [63:0] SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

	typedef struct packed {
		logic signed [ACC_W-1:0] acc;
		logic [WGT_W-1:0]        w_left;
		logic [WGT_W-1:0]        w_up;
		logic [WGT_W-1:0]        w_diag;
		logic                    last;
	} cell_result_t;

	logic [63:0] pow2_lut [DEPTH];
	logic [63:0] log2_lut [DEPTH];

	logic [10:0] rows_reg, cols_reg;
	logic [7:0]  sharp_reg;
	logic signed [63:0] row_above [LIM];
	logic signed [63:0] left_acc, diag_acc;
	int unsigned row_pos, col_pos;
	cell_result_t expected_cells [$];

	function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
		logic [63:0] v, r, b;
		v = v_in;
		r = '0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	initial begin
		logic [63:0] roots [33];
		logic [63:0] frac, prod, y, lg;
		roots[0] = 64'd1 << 31;
		for (int b = 1; b <= 32; b++) roots[b] = int_sqrt(roots[b-1] << 32);
		for (int k = 0; k < DEPTH; k++) begin
			frac = (64'(k) << 32) / DEPTH;
			prod = 64'd1 << 32;
			for (int p = 31; p >= 0; p--)
				if (frac[p]) prod = (prod * roots[32-p]) >> 32;
			pow2_lut[k] = prod;
			y  = (64'd1 << 30) + ((64'(k) << 30) / DEPTH);
			lg = '0;
			for (int p = 31; p >= 0; p--) begin
				y = (y * y) >> 30;
				if (y >= (64'd2 << 30)) begin
					y = y >> 1;
					lg[p] = 1'b1;
				end
			end
			log2_lut[k] = lg;
		end
	end

	// Natural exponent of -n*d, taken in base two through the Q1.32 power table.
	function automatic logic [63:0] exp_weight(input logic signed [63:0] d,
			input logic [63:0] n);
		logic [63:0] u, p, idx;
		if (d >= 64'sd4294967296) return 64'd0;
		u = (64'(d) * n * 64'd94548) >> 16;
		p = u >> 16;
		if (p >= 17) return 64'd0;
		idx = ((u & 64'hFFFF) * DEPTH) >> 16;
		return pow2_lut[idx] >> (16 + p);
	endfunction

	function automatic logic [63:0] log_of_sum(input logic [63:0] z);
		logic [63:0] g, f, l;
		g = 0;
		if (z >= 64'd131072) begin
			g = 1;
			f = (z >> 1) - 64'd65536;
		end else begin
			f = z - 64'd65536;
		end
		if (f > 64'd65535) f = 64'd65535;
		l = (g << 32) + log2_lut[(f * DEPTH) >> 16];
		return (l * 64'd45426) >> 32;
	endfunction

	function automatic cell_result_t next_cell(input logic signed [COST_W-1:0] c_in);
		int unsigned nrows, ncols, r, c;
		logic [63:0] n, z, lnz;
		logic signed [63:0] x [3];
		logic [63:0] e [3];
		logic signed [63:0] xmin, acc, up;
		logic row_end;
		cell_result_t res;
		nrows = (rows_reg == 0) ? 1 : (rows_reg > MAX_ROWS_T) ? MAX_ROWS_T : rows_reg;
		ncols = (cols_reg == 0) ? 1 : (cols_reg > LIM) ? LIM : cols_reg;
		n = (sharp_reg == 0) ? 64'd1 : 64'(sharp_reg);
		r = row_pos;
		c = (col_pos >= LIM) ? LIM - 1 : col_pos;
		up   = (r == 0) ? SAT_HI : row_above[c];
		x[0] = (c == 0) ? SAT_HI : left_acc;
		x[1] = up;
		x[2] = (c == 0 && r != 0) ? SAT_HI : diag_acc;
		xmin = x[0];
		for (int i = 1; i < 3; i++) if (x[i] < xmin) xmin = x[i];
		z = 0;
		for (int i = 0; i < 3; i++) begin
			e[i] = exp_weight(x[i] - xmin, n);
			z = z + e[i];
		end
		lnz = log_of_sum(z);
		acc = 64'(c_in) + xmin - $signed(lnz / n);
		if (acc > SAT_HI) acc = SAT_HI;
		if (acc < SAT_LO) acc = SAT_LO;
		row_end = (c + 1 >= ncols);
		res.acc    = acc[ACC_W-1:0];
		res.w_left = WGT_W'((e[0] << 16) / z);
		res.w_up   = WGT_W'((e[1] << 16) / z);
		res.w_diag = WGT_W'((e[2] << 16) / z);
		res.last   = row_end && (r + 1 >= nrows);
		row_above[c] = acc;
		left_acc = acc;
		diag_acc = up;
		if (res.last) begin
			row_pos = 0;
			col_pos = 0;
			left_acc = SAT_HI;
			diag_acc = 0;
		end else if (row_end) begin
			row_pos = r + 1;
			col_pos = 0;
			left_acc = SAT_HI;
			diag_acc = SAT_HI;
		end else begin
			col_pos = c + 1;
		end
		return res;
	endfunction

	assign pending = expected_cells.size();

	always @(posedge clk or negedge arst_n) begin
		cell_result_t want;
		if (!arst_n) begin
			rows_reg  <= 11'd1;
			cols_reg  <= 11'd1;
			sharp_reg <= 8'd1;
			left_acc  = SAT_HI;
			diag_acc  = 0;
			row_pos   = 0;
			col_pos   = 0;
			expected_cells.delete();
			errors    <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_ROW_COUNT: rows_reg  <= pwdata[10:0];
					REG_COL_COUNT: cols_reg  <= pwdata[10:0];
					REG_SHARPNESS: sharp_reg <= pwdata[7:0];
					default: ;
				endcase
			end
			if (cell_valid && cell_ready) expected_cells.push_back(next_cell(cost));
			if (result_valid && result_ready) begin
				if (expected_cells.size() == 0) begin
					$error("unexpected result word, accumulated %0d", accumulated);
					errors <= errors + 1;
				end else begin
					want = expected_cells.pop_front();
					if (accumulated !== want.acc || weight_left !== want.w_left ||
							weight_up !== want.w_up || weight_diag !== want.w_diag ||
							last_cell !== want.last) begin
						if (accumulated !== want.acc)
							$error("accumulated: expected %0d, got %0d", want.acc, accumulated);
						if (weight_left !== want.w_left)
							$error("weight_left: expected %0d, got %0d", want.w_left, weight_left);
						if (weight_up !== want.w_up)
							$error("weight_up: expected %0d, got %0d", want.w_up, weight_up);
						if (weight_diag !== want.w_diag)
							$error("weight_diag: expected %0d, got %0d", want.w_diag, weight_diag);
						if (last_cell !== want.last)
							$error("last_cell: expected %0d, got %0d", want.last, last_cell);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

>>> sim/tb_soft_dtw_forward_cell_core.sv
`timescale 1ns / 100ps

module tb_soft_dtw_forward_cell_core;
	import sdtw_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int DRAIN_CYCLES = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic cell_valid = 1'b0;
	logic cell_ready;
	logic signed [COST_W-1:0] cost = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [ACC_W-1:0] accumulated;
	logic [WGT_W-1:0] weight_left, weight_up, weight_diag;
	logic last_cell;
	int pending, errors;
	int send_idle = 0, recv_idle = 0;
	int cycles = 0;
	int sent;

	always #5 clk = ~clk;

	soft_dtw_forward_cell_core dut (.*);

	soft_dtw_cell_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk) result_ready <= ($urandom_range(99) >= recv_idle);

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Drain everything in flight, then give the core time to go idle.
	task automatic settle();
		@(negedge clk);
		cell_valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic send_word(input logic [31:0] val);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			cell_valid <= 1'b0;
			@(negedge clk);
		end
		cell_valid <= 1'b1;
		cost <= val;
		do @(posedge clk); while (!cell_ready);
		sent++;
	endtask

	function automatic logic [31:0] pick_cost(input int kind);
		case (kind)
			0: return $urandom;
			1: return 32'($urandom_range(0, 8 << 16)) - 32'(4 << 16);
			default: return 32'($urandom_range(0, 32'h800)) - 32'h400;
		endcase
	endfunction

	task automatic run_matrix(input int rows, input int cols, input int sharp, input int kind);
		int nr, nc;
		settle();
		reg_write(REG_ROW_COUNT, rows);
		reg_write(REG_COL_COUNT, cols);
		reg_write(REG_SHARPNESS, sharp);
		nr = (rows == 0) ? 1 : (rows > 1024) ? 1024 : rows;
		nc = (cols == 0) ? 1 : (cols > 1024) ? 1024 : cols;
		for (int i = 0; i < nr * nc; i++) send_word(pick_cost(kind));
	endtask

	task automatic random_phase(input int count);
		int start;
		start = sent;
		while (sent - start < count) begin
			if ($urandom_range(9) == 0)
				run_matrix($urandom_range(0, 2047) % 5, $urandom_range(0, 2047) % 9,
					$urandom_range(0, 255), $urandom_range(0, 2));
			else
				run_matrix($urandom_range(1, 6), $urandom_range(1, 8),
					($urandom_range(1) != 0) ? $urandom_range(1, 4) : $urandom_range(0, 255),
					$urandom_range(0, 2));
		end
	endtask

	initial begin
		sent = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle = 28;
		recv_idle = 84;

		// One cell with the reset configuration.
		send_word(32'h0001_0000);
		settle();
		reg_write(REG_ROW_COUNT, 2);
		reg_write(REG_COL_COUNT, 3);
		reg_write(REG_SHARPNESS, 1);
		send_word(32'h8000_0000);
		send_word(32'h7FFF_FFFF);
		send_word(32'h0000_0000);
		send_word(32'h0000_0001);
		send_word(32'hFFFF_FFFF);
		send_word(32'h0001_0000);
		run_matrix(0, 0, 0, 0);
		run_matrix(3, 3, 255, 2);
		run_matrix(3, 4, 1, 2);
		random_phase(300);

		send_idle = 84;
		recv_idle = 28;
		random_phase(300);

		send_idle = 0;
		recv_idle = 0;
		run_matrix(1, 40, 2, 1);
		run_matrix(40, 1, 1, 1);
		random_phase(300);

		settle();
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/sdtw_pkg.sv
rtl/core/sdtw_div.sv
rtl/core/sdtw_rom.sv
rtl/core/soft_dtw_forward_cell_core.sv
sim/soft_dtw_cell_checker.sv
sim/tb_soft_dtw_forward_cell_core.sv
